[src/i2c_transaction_sequencer_core_defines.svh]
// Assertion macros shared by the I2C transaction sequencer RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef I2C_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH
`define I2C_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define I2CTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define I2CTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define I2CTS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define I2CTS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/i2cts_pkg.sv]
// Types and constants for the I2C transaction sequencer.
// Used by i2c_transaction_sequencer_core; depends on nothing.
package i2cts_pkg;

    localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

    localparam logic [15:0] MODE_BASE_WRITE = 16'h4620;
    localparam logic [15:0] MODE_BASE_READ  = 16'h4420;
    localparam logic [15:0] MODE_STOP_BIT   = 16'h0800;
    localparam logic [15:0] MODE_START_BIT  = 16'h2000;

    localparam logic [15:0] MODE_WRITE_STOP = MODE_BASE_WRITE | MODE_START_BIT | MODE_STOP_BIT;
    localparam logic [15:0] MODE_WRITE      = MODE_BASE_WRITE | MODE_START_BIT;
    localparam logic [15:0] MODE_READ_STOP  = MODE_BASE_READ | MODE_START_BIT | MODE_STOP_BIT;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_SEND_STOP   = 3'd1,
        PH_WRITE_BUSY  = 3'd2,
        PH_SEND_NOSTOP = 3'd3,
        PH_NOSTOP_BUSY = 3'd4,
        PH_RESTART     = 3'd5,
        PH_READ_BUSY   = 3'd6,
        PH_FAILED      = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_POLL  = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CMD_WRITE_STOP = 2'd0,
        CMD_WRITE_READ = 2'd1,
        CMD_READ_ONLY  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  slave_address;
        logic [1:0]  command;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [15:0] elapsed_time;
        logic        arb_lost;
        logic        nack_seen;
        logic        stop_seen;
        logic        shift_empty;
        logic        access_ready;
    } seq_in_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        issue_transfer;
        logic [9:0]  target_address;
        logic [15:0] transfer_count;
        logic [15:0] mode_word;
        logic        fifo_clear;
        logic        bus_reset;
        logic [15:0] message_total;
        logic [15:0] arb_loss_total;
        logic [15:0] nack_total;
        logic [15:0] timeout_total;
    } seq_out_t;

endpackage

[src/i2c_transaction_sequencer_core.sv]
// I2C master message sequencer: phase control, busy timer and event counters.
// Depends on i2cts_pkg and i2c_transaction_sequencer_core_defines.svh.
//
//   channel  | ports                        | carries
//   ---------+------------------------------+-------------------------------
//   input    | s_valid, s_ready, s_data     | one seq_in_t word per item
//   result   | m_valid, m_ready, m_data     | one seq_out_t word per item
//   config   | cfg_we, cfg_wdata            | busy_timeout, no read-back
//
// The phase, timer and counters update at the edge that accepts an item,
// and the result word is in m_data from the next cycle.
// One result register sits on the output; s_ready is high whenever that
// register is empty or is being drained, so a full rate of one word per
// cycle holds as long as m_ready stays high. Reset clears the phase, the
// saved operands, the timer, the counters and the result valid.
`include "i2c_transaction_sequencer_core_defines.svh"

module i2c_transaction_sequencer_core
    import i2cts_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  seq_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output seq_out_t    m_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]            busy_timeout_reg;
    phase_t                 phase_reg, phase_next;
    logic [9:0]             saved_addr_reg;
    logic [COUNT_WIDTH-1:0] saved_wr_cnt_reg;
    logic [COUNT_WIDTH-1:0] saved_rd_cnt_reg;
    logic [15:0]            busy_timer_reg, busy_timer_next;
    logic [15:0]            msg_cnt_reg, msg_cnt_next;
    logic [15:0]            arb_cnt_reg, arb_cnt_next;
    logic [15:0]            nack_cnt_reg, nack_cnt_next;
    logic [15:0]            tmo_cnt_reg, tmo_cnt_next;
    logic                   m_valid_reg;
    seq_out_t               m_data_reg, m_data_next;

    logic        accept;
    logic        is_start, is_poll, is_tick;
    logic        timed_out;
    logic        issue;
    logic [15:0] issue_count;
    logic [15:0] issue_mode;
    logic        bus_reset;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign is_start  = (s_data.action == ACT_START);
    assign is_poll   = (s_data.action == ACT_POLL);
    assign is_tick   = (s_data.action == ACT_TICK);
    assign timed_out = (busy_timer_reg == 16'd0);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (is_start) begin
            case (s_data.command)
                CMD_WRITE_STOP: phase_next = PH_SEND_STOP;
                CMD_WRITE_READ: phase_next = PH_SEND_NOSTOP;
                CMD_READ_ONLY:  phase_next = PH_RESTART;
                default:        phase_next = PH_IDLE;
            endcase
        end else if (is_poll) begin
            if (s_data.arb_lost) begin
                phase_next = PH_FAILED;
            end else begin
                case (phase_reg)
                    PH_SEND_STOP:   phase_next = PH_WRITE_BUSY;
                    PH_SEND_NOSTOP: phase_next = PH_NOSTOP_BUSY;
                    PH_RESTART:     phase_next = PH_READ_BUSY;
                    PH_WRITE_BUSY, PH_READ_BUSY: begin
                        if (timed_out || s_data.nack_seen) begin
                            phase_next = PH_FAILED;
                        end else if (s_data.stop_seen) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_NOSTOP_BUSY: begin
                        if (timed_out || s_data.nack_seen) begin
                            phase_next = PH_FAILED;
                        end else if (s_data.shift_empty && s_data.access_ready) begin
                            phase_next = PH_READ_BUSY;
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // Issue decisions, timer and counters.
    always_comb begin
        issue           = 1'b0;
        issue_count     = 16'd0;
        issue_mode      = 16'd0;
        bus_reset       = 1'b0;
        busy_timer_next = busy_timer_reg;
        msg_cnt_next    = msg_cnt_reg;
        arb_cnt_next    = arb_cnt_reg;
        nack_cnt_next   = nack_cnt_reg;
        tmo_cnt_next    = tmo_cnt_reg;
        if (is_poll) begin
            if (s_data.arb_lost) begin
                bus_reset    = 1'b1;
                arb_cnt_next = arb_cnt_reg + 16'd1;
            end else begin
                case (phase_reg)
                    PH_SEND_STOP: begin
                        issue        = 1'b1;
                        issue_count  = 16'(saved_wr_cnt_reg);
                        issue_mode   = MODE_WRITE_STOP;
                        msg_cnt_next = msg_cnt_reg + 16'd1;
                    end
                    PH_SEND_NOSTOP: begin
                        issue        = 1'b1;
                        issue_count  = 16'(saved_wr_cnt_reg);
                        issue_mode   = MODE_WRITE;
                        msg_cnt_next = msg_cnt_reg + 16'd1;
                    end
                    PH_RESTART: begin
                        issue       = 1'b1;
                        issue_count = 16'(saved_rd_cnt_reg);
                        issue_mode  = MODE_READ_STOP;
                    end
                    PH_WRITE_BUSY, PH_READ_BUSY, PH_NOSTOP_BUSY: begin
                        if (timed_out) begin
                            bus_reset    = 1'b1;
                            tmo_cnt_next = tmo_cnt_reg + 16'd1;
                        end else if (s_data.nack_seen) begin
                            nack_cnt_next = nack_cnt_reg + 16'd1;
                        end else if (phase_reg == PH_NOSTOP_BUSY
                                     && s_data.shift_empty && s_data.access_ready) begin
                            issue       = 1'b1;
                            issue_count = 16'(saved_rd_cnt_reg);
                            issue_mode  = MODE_READ_STOP;
                        end
                    end
                    default: issue = 1'b0;
                endcase
            end
            if (issue) begin
                busy_timer_next = busy_timeout_reg;
            end
        end else if (is_tick) begin
            busy_timer_next = (busy_timer_reg > s_data.elapsed_time)
                            ? (busy_timer_reg - s_data.elapsed_time) : 16'd0;
        end
    end

    always_comb begin
        m_data_next.phase          = phase_next;
        m_data_next.issue_transfer = issue;
        m_data_next.target_address = issue ? saved_addr_reg : 10'd0;
        m_data_next.transfer_count = issue_count;
        m_data_next.mode_word      = issue_mode;
        m_data_next.fifo_clear     = issue;
        m_data_next.bus_reset      = bus_reset;
        m_data_next.message_total  = msg_cnt_next;
        m_data_next.arb_loss_total = arb_cnt_next;
        m_data_next.nack_total     = nack_cnt_next;
        m_data_next.timeout_total  = tmo_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_timeout_reg <= 16'd0;
            phase_reg        <= PH_IDLE;
            saved_addr_reg   <= 10'd0;
            saved_wr_cnt_reg <= '0;
            saved_rd_cnt_reg <= '0;
            busy_timer_reg   <= 16'd0;
            msg_cnt_reg      <= 16'd0;
            arb_cnt_reg      <= 16'd0;
            nack_cnt_reg     <= 16'd0;
            tmo_cnt_reg      <= 16'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                busy_timeout_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg      <= phase_next;
                busy_timer_reg <= busy_timer_next;
                msg_cnt_reg    <= msg_cnt_next;
                arb_cnt_reg    <= arb_cnt_next;
                nack_cnt_reg   <= nack_cnt_next;
                tmo_cnt_reg    <= tmo_cnt_next;
                if (is_start) begin
                    saved_addr_reg   <= s_data.slave_address;
                    saved_wr_cnt_reg <= COUNT_WIDTH'(s_data.write_count);
                    saved_rd_cnt_reg <= COUNT_WIDTH'(s_data.read_count);
                end
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // The input side is only blocked while a result is held.
    `I2CTS_ASSERT_IMP(a_ready_only_when_drained, aclk, aresetn, !s_ready, m_valid_reg)

    // A programmed transfer always lands in a busy phase.
    `I2CTS_ASSERT_IMP(a_issue_enters_busy, aclk, aresetn, m_valid_reg && m_data_reg.issue_transfer,
        m_data_reg.fifo_clear && (m_data_reg.phase == PH_WRITE_BUSY
        || m_data_reg.phase == PH_NOSTOP_BUSY || m_data_reg.phase == PH_READ_BUSY))

    // Bus recovery is only requested on the way into the failed phase.
    `I2CTS_ASSERT_IMP(a_reset_means_failed, aclk, aresetn, m_valid_reg && m_data_reg.bus_reset,
        m_data_reg.phase == PH_FAILED && !m_data_reg.issue_transfer)

    // A clean poll in a send phase counts exactly one message.
    `I2CTS_ASSERT_NXT(a_message_counted, aclk, aresetn,
        accept && is_poll && !s_data.arb_lost
        && (phase_reg == PH_SEND_STOP || phase_reg == PH_SEND_NOSTOP),
        msg_cnt_reg == $past(msg_cnt_reg) + 16'd1)

    // Arbitration loss wins over everything else on a poll.
    `I2CTS_ASSERT_NXT(a_arb_loss_fails, aclk, aresetn, accept && is_poll && s_data.arb_lost,
        phase_reg == PH_FAILED && m_data_reg.bus_reset && !m_data_reg.issue_transfer)

endmodule
